// ===== hdl/uart_frame_deframer_macros.svh =====
`ifndef UART_FRAME_DEFRAMER_MACROS_SVH
`define UART_FRAME_DEFRAMER_MACROS_SVH
// assertion helpers
`define UFD_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define UFD_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// ===== hdl/ufd_pkg.sv =====
`default_nettype none
package ufd_pkg;
  localparam int BufBytes      = 64;
  localparam int FrameOverhead = 9;
  localparam int VersionOffset = 2;
  localparam int LengthOffset  = 6;
  localparam int RegIdxW       = 2;
  localparam logic [RegIdxW-1:0] REG_HEADER_FIRST  = 2'd0;
  localparam logic [RegIdxW-1:0] REG_HEADER_SECOND = 2'd1;
  localparam logic [RegIdxW-1:0] REG_VERSION       = 2'd2;

  typedef struct packed {
    logic in_fire;
    logic scan_clr;
    logic ld_first;
    logic ld_next;
    logic ld_ver;
    logic ld_lenh;
    logic ld_lenl;
    logic sum_clr;
    logic sum_add;
    logic emit;
    logic advance;
    logic adv_frame;
    logic [1:0] adv_n;
    logic compact;
    logic comp_done;
  } ufd_cmd_t;

  typedef struct packed {
    logic avail_ovh;
    logic hdr_ok;
    logic ver_ok;
    logic len_big;
    logic incomplete;
    logic idx_last;
    logic sum_ok;
    logic comp_end;
  } ufd_stat_t;
endpackage
`default_nettype wire

// ===== hdl/ufd_stream_if.sv =====
`default_nettype none
interface ufd_stream_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/ufd_out_if.sv =====
`default_nettype none
interface ufd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_first;
  logic       frame_last;
  logic       run_last;
  modport source (output valid, output frame_byte, output frame_first, output frame_last,
                  output run_last, input ready);
  modport sink (input valid, input frame_byte, input frame_first, input frame_last,
                input run_last, output ready);
endinterface
`default_nettype wire

// ===== hdl/uart_frame_deframer.sv =====
// channel | dir | payload
// rx      | in  | rx_byte[7:0]
// frame   | out | frame_byte[7:0], frame_first, frame_last, run_last
// Each byte is accepted and then scanned: header and version checks, a length check,
// a checksum sum and emit for a good frame, and a compaction of the bytes kept in the
// buffer, paced by the single read port of the byte buffer.
// Synchronous reset clears counts and state; register values return to defaults.
// Output backpressure stalls the scan; one output word is held in a register.
`default_nettype none
`include "uart_frame_deframer_macros.svh"
module uart_frame_deframer import ufd_pkg::*; #(
  parameter int BUF_BYTES      = BufBytes,
  parameter int FRAME_OVERHEAD = FrameOverhead,
  parameter int VERSION_OFFSET = VersionOffset,
  parameter int LENGTH_OFFSET  = LengthOffset
) (
  input wire logic clk,
  input wire logic rst,
  ufd_stream_if.sink rx,
  ufd_out_if.source frame,
  input wire logic               cfg_we,
  input wire logic [RegIdxW-1:0] cfg_idx,
  input wire logic [7:0]         cfg_data
);
  ufd_cmd_t   cmd;
  ufd_stat_t  stat;
  logic [7:0] header_first, header_second, protocol_version;
  logic [7:0] rd_byte, frame_byte;
  logic       rd_first, frame_first, frame_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first <= 8'd85;
      header_second <= 8'd170;
      protocol_version <= 8'd2;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_HEADER_FIRST: header_first <= cfg_data;
        REG_HEADER_SECOND: header_second <= cfg_data;
        REG_VERSION: protocol_version <= cfg_data;
        default: ;
      endcase
    end
  end

  ufd_ctrl u_ctrl (
    .clk, .rst, .in_valid(rx.valid), .in_ready(rx.ready), .out_valid(frame.valid),
    .out_ready(frame.ready), .out_run_last(frame.run_last), .stat, .cmd
  );

  ufd_datapath #(.BUF_BYTES(BUF_BYTES), .FRAME_OVERHEAD(FRAME_OVERHEAD),
    .VERSION_OFFSET(VERSION_OFFSET), .LENGTH_OFFSET(LENGTH_OFFSET)) u_dp (
    .clk, .rst, .cmd, .rx_byte(rx.data), .hdr_a(header_first), .hdr_b(header_second),
    .ver(protocol_version), .stat, .rd_byte, .rd_first
  );

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      frame_byte <= rd_byte;
      frame_first <= rd_first;
      frame_last <= stat.idx_last;
    end
  end
  assign frame.frame_byte = frame_byte;
  assign frame.frame_first = frame_first;
  assign frame.frame_last = frame_last;

  `UFD_ASSERT_IMP(a_no_in_busy, clk, rst, rx.valid && rx.ready, !frame.valid, "input while output pending")
  `UFD_ASSERT_NEXT(a_out_hold, clk, rst, frame.valid && !frame.ready, frame.valid && $stable(frame.frame_byte), "output word changed while stalled")
  `UFD_ASSERT_IMP(a_last_first, clk, rst, frame.valid && frame.run_last, frame.frame_last, "run_last off frame end")
endmodule
`default_nettype wire

// ===== hdl/ufd_datapath.sv =====
`default_nettype none
module ufd_datapath import ufd_pkg::*; #(
  parameter int BUF_BYTES      = BufBytes,
  parameter int FRAME_OVERHEAD = FrameOverhead,
  parameter int VERSION_OFFSET = VersionOffset,
  parameter int LENGTH_OFFSET  = LengthOffset
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire ufd_cmd_t   cmd,
  input  wire logic [7:0] rx_byte,
  input  wire logic [7:0] hdr_a,
  input  wire logic [7:0] hdr_b,
  input  wire logic [7:0] ver,
  output      ufd_stat_t  stat,
  output      logic [7:0] rd_byte,
  output      logic       rd_first
);
  localparam int AW = $clog2(BUF_BYTES);
  localparam int CW = $clog2(BUF_BYTES + 1);
  localparam int LW = 17;

  logic [7:0] mem [BUF_BYTES];
  logic [CW-1:0] fill_count;
  logic [CW-1:0] scan_start;
  logic [CW-1:0] idx;
  logic [CW-1:0] comp_idx;
  logic [CW-1:0] fill_next;
  logic [CW-1:0] scan_next;
  logic [CW-1:0] idx_next;
  logic [CW-1:0] comp_idx_next;
  logic [LW-1:0] flen;
  logic [7:0]    sum;
  logic [7:0]    b0;
  logic          h_ok;
  logic [CW:0]   rd_pos;
  logic [CW:0]   rd_pos_next;
  logic [CW:0]   wr_pos;
  logic          in_rng;
  logic [7:0]    rd_q;
  logic [7:0]    pk;

  // idx stays zero while compacting and comp_idx stays zero while scanning
  assign rd_pos = {1'b0, scan_start} + {1'b0, idx} + {1'b0, comp_idx};
  // read ahead from the next position so rd_q holds the byte at rd_pos
  assign rd_pos_next = {1'b0, scan_next} + {1'b0, idx_next} + {1'b0, comp_idx_next};
  assign in_rng = rd_pos < {1'b0, fill_count};
  assign wr_pos = {1'b0, fill_count};

  always_ff @(posedge clk) begin
    if (cmd.in_fire && wr_pos < (CW+1)'(BUF_BYTES)) mem[wr_pos[AW-1:0]] <= rx_byte;
    else if (cmd.comp_done) mem[comp_idx[AW-1:0]] <= pk;
    rd_q <= mem[rd_pos_next[AW-1:0]];
  end
  assign pk = in_rng ? rd_q : 8'd0;
  assign rd_byte  = pk;
  assign rd_first = (idx == '0);

  always_comb begin
    fill_next = fill_count;
    scan_next = scan_start;
    idx_next = idx;
    comp_idx_next = comp_idx;
    if (cmd.in_fire && fill_count < CW'(BUF_BYTES)) fill_next = fill_count + CW'(1);
    if (cmd.scan_clr) begin
      scan_next = '0;
      idx_next = '0;
      comp_idx_next = '0;
    end
    if (cmd.ld_first) idx_next = CW'(1);
    if (cmd.ld_next) idx_next = CW'(VERSION_OFFSET);
    if (cmd.ld_ver) idx_next = CW'(LENGTH_OFFSET);
    if (cmd.ld_lenh) idx_next = CW'(LENGTH_OFFSET + 1);
    if (cmd.ld_lenl || cmd.sum_clr) idx_next = '0;
    if (cmd.sum_add || cmd.emit) idx_next = idx + CW'(1);
    if (cmd.advance) begin
      scan_next = cmd.adv_frame ? scan_start + flen[CW-1:0]
                                : scan_start + CW'(cmd.adv_n);
      idx_next = '0;
    end
    if (cmd.comp_done) comp_idx_next = comp_idx + CW'(1);
    if (cmd.compact && stat.comp_end) begin
      fill_next = fill_count - scan_start;
      scan_next = '0;
      comp_idx_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      scan_start <= '0;
      idx <= '0;
      comp_idx <= '0;
    end else begin
      fill_count <= fill_next;
      scan_start <= scan_next;
      idx <= idx_next;
      comp_idx <= comp_idx_next;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.ld_first) b0 <= pk;
    if (cmd.ld_next) h_ok <= (b0 == hdr_a) && (pk == hdr_b);
    if (cmd.ld_lenh) flen <= {1'b0, pk, 8'd0};
    if (cmd.ld_lenl) flen <= flen + {9'd0, pk} + LW'(FRAME_OVERHEAD);
    if (cmd.sum_clr) sum <= '0;
    else if (cmd.sum_add) sum <= sum + pk;
  end

  always_comb begin
    stat.avail_ovh  = (fill_count - scan_start) >= CW'(FRAME_OVERHEAD);
    stat.hdr_ok     = h_ok;
    stat.ver_ok     = pk == ver;
    stat.len_big    = flen > LW'(BUF_BYTES);
    stat.incomplete = {{(LW-CW){1'b0}}, fill_count - scan_start} < flen;
    stat.idx_last   = {{(LW-CW){1'b0}}, idx} + LW'(1) == flen;
    stat.sum_ok     = sum == pk;
    stat.comp_end   = comp_idx == fill_count - scan_start;
  end
endmodule
`default_nettype wire

// ===== hdl/ufd_ctrl.sv =====
`default_nettype none
module ufd_ctrl import ufd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output      logic      in_ready,
  output      logic      out_valid,
  input  wire logic      out_ready,
  output      logic      out_run_last,
  input  wire ufd_stat_t stat,
  output      ufd_cmd_t  cmd
);
  localparam logic [3:0] S_IDLE = 4'd0, S_CHK = 4'd1, S_H0 = 4'd2, S_H1 = 4'd3,
                         S_VER = 4'd4, S_LH = 4'd5, S_LL = 4'd6, S_LEN = 4'd7,
                         S_SUM = 4'd8, S_CS = 4'd9, S_EMIT = 4'd10, S_COMP = 4'd11,
                         S_CW = 4'd12;
  logic [3:0] state, state_next;
  logic       pend;
  logic       pend_next;

  // a word waits in pend so run_last can be known
  always_comb begin
    cmd = '0;
    state_next = state;
    pend_next = pend;
    in_ready = (state == S_IDLE) && !pend;
    out_valid = pend && (state == S_EMIT || state == S_IDLE || state == S_COMP ||
                         state == S_CW);
    out_run_last = pend && (state == S_IDLE || state == S_COMP || state == S_CW);
    if (out_valid && out_ready) pend_next = 1'b0;
    case (state)
      S_IDLE: if (in_valid && in_ready) begin
        cmd.in_fire = 1'b1;
        cmd.scan_clr = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: state_next = stat.avail_ovh ? S_H0 : S_COMP;
      S_H0: begin cmd.ld_first = 1'b1; state_next = S_H1; end
      S_H1: begin cmd.ld_next = 1'b1; state_next = S_VER; end
      S_VER: begin
        if (!stat.hdr_ok) begin
          cmd.advance = 1'b1; cmd.adv_n = 2'd1; state_next = S_CHK;
        end else if (!stat.ver_ok) begin
          cmd.advance = 1'b1; cmd.adv_n = 2'd2; state_next = S_CHK;
        end else begin
          cmd.ld_ver = 1'b1; state_next = S_LH;
        end
      end
      S_LH: begin cmd.ld_lenh = 1'b1; state_next = S_LL; end
      S_LL: begin cmd.ld_lenl = 1'b1; state_next = S_LEN; end
      S_LEN: begin
        if (stat.len_big) begin
          cmd.advance = 1'b1; cmd.adv_n = 2'd3; state_next = S_CHK;
        end else if (stat.incomplete) state_next = S_COMP;
        else begin cmd.sum_clr = 1'b1; state_next = S_SUM; end
      end
      S_SUM: if (stat.idx_last) state_next = S_CS;
             else cmd.sum_add = 1'b1;
      S_CS: begin
        if (stat.sum_ok) begin cmd.sum_clr = 1'b1; state_next = S_EMIT; end
        else begin cmd.advance = 1'b1; cmd.adv_n = 2'd3; state_next = S_CHK; end
      end
      S_EMIT: if (!pend || (out_valid && out_ready)) begin
        if (pend && out_ready) pend_next = 1'b0;
        if (!pend || out_ready) begin
          pend_next = 1'b1;
          cmd.emit = 1'b1;
          if (stat.idx_last) begin
            cmd.advance = 1'b1; cmd.adv_frame = 1'b1; state_next = S_CHK;
          end
        end
      end
      S_COMP: if (!pend || out_ready) begin
        cmd.compact = 1'b1;
        if (stat.comp_end) state_next = S_IDLE;
        else state_next = S_CW;
      end
      S_CW: begin cmd.compact = 1'b1; cmd.comp_done = 1'b1; state_next = S_COMP; end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend <= 1'b0;
    end else begin
      state <= state_next;
      pend <= pend_next;
    end
  end
endmodule
`default_nettype wire
